// ===== rtl/core/btc_pkg.sv =====
// btc_pkg: shared constants, codes and types of the blank-run-to-tab compressor.
// No dependencies; every other file of the block imports it.

package btc_pkg;

  // Sizing
  localparam int NUM_STOPS  = 6;
  localparam int COUNT_BITS = 12;
  localparam int REG_STOPS  = 6;
  localparam int CNT_W      = COUNT_BITS;
  localparam int CNT_W1     = CNT_W + 1;
  localparam int SC_W       = 3;
  localparam int TW_W       = 5;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CNT_W;
  localparam int BIT_IDX_W  = $clog2(CNT_W);
  localparam int STOP_IDX_W = $clog2(REG_STOPS);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_5     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH  = 3'd7;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [BYTE_W-1:0] CH_BLANK   = 8'd32;

  typedef logic [REG_STOPS-1:0][CNT_W-1:0] stops_t;

  // Register reset values
  localparam logic [SC_W-1:0] STOP_COUNT_RST = '0;
  localparam logic [TW_W-1:0] TAB_WIDTH_RST  = 5'd8;
  localparam stops_t STOPS_RST = {CNT_W'(49), CNT_W'(41), CNT_W'(33),
                                  CNT_W'(25), CNT_W'(17), CNT_W'(9)};

  // Remainder unit request and response
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [TW_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [TW_W-1:0] rem;
  } rem_rsp_t;

  // Next tab stop as seen from the current column
  typedef struct packed {
    logic             hit;
    logic             need_phase;
    logic             dflt_clamped;
    logic [CNT_W-1:0] stop;
  } stop_sel_t;

endpackage

// ===== rtl/core/btc_ifs.sv =====
// btc_ifs: valid/ready channel interfaces of the blank-run-to-tab compressor.
// Depends on btc_pkg for field widths.

interface btc_in_if import btc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface btc_out_if import btc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  tab_count;
  logic [CNT_W-1:0]  space_count;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;

  modport source (output valid, output tab_count, output space_count, output out_byte,
                  output byte_valid, input ready);
  modport sink   (input valid, input tab_count, input space_count, input out_byte,
                  input byte_valid, output ready);
endinterface

interface btc_cfg_if import btc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/blank_run_to_tab_compressor.sv =====
// blank_run_to_tab_compressor: top level, configuration registers, step sequencer
// and output register. Depends on btc_pkg, btc_ifs, btc_rem_unit, btc_stop_pick.
//
// Usage
//   in_i  : text bytes plus an end-of-stream flag, one beat per byte.
//   out_o : one beat per non-blank byte (tabs, spaces, byte) and one per
//           end of stream (spaces only, byte_valid low). Blanks give no beat.
//   cfg_i : register writes, always ready; write only while the block is idle.
// Sequence
//   A blank beat only extends the pending run. Any other byte is accepted,
//   then the run is flushed one tab or space per step, then the byte itself
//   advances the column and the result is loaded into the output register.
//   An end-of-stream beat flushes the whole run as spaces in a single step.
//   When the column's place on the default stop grid is not known (after a
//   jump to a listed stop, a clamp at the count limit or a tab_width write),
//   the bit-serial remainder unit runs before the next step.
//   The flush loop sets the rate: one tab or space per cycle outside S_MOD.
// Reset and stalls
//   Reset sets column 1, no pending blanks and the register defaults.
//   The input is ready only while the sequencer is idle; a result waiting in
//   the output register does not block blank beats, but the next result waits
//   until the receiver takes the previous one.

module blank_run_to_tab_compressor import btc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  btc_in_if.sink     in_i,
  btc_out_if.source  out_o,
  btc_cfg_if.sink    cfg_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  // Configuration
  logic [SC_W-1:0] stop_cnt_q;
  stops_t          stops_q;
  logic [TW_W-1:0] tab_w_q;
  logic [TW_W-1:0] w_eff;
  logic            cfg_wr;

  // Sequencer state
  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] pend_q, pend_d;
  logic [TW_W-1:0]  phase_q, phase_d;
  logic             phase_vld_q, phase_vld_d;
  logic [CNT_W-1:0] tabs_q, tabs_d;
  logic [CNT_W-1:0] spc_q, spc_d;
  logic [BYTE_W-1:0] byte_q;
  logic             eos_q;

  // Output register
  logic              out_vld_q, out_vld_d;
  logic [CNT_W-1:0]  out_tab_q;
  logic [CNT_W-1:0]  out_spc_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_bv_q;
  logic              load_out;

  // Helpers
  logic             in_acc;
  logic [CNT_W-1:0] col_inc;
  logic [TW_W-1:0]  phase_inc;
  logic [CNT_W-1:0] gap;
  logic             take_tab;
  rem_req_t         rem_req;
  rem_rsp_t         rem_rsp;
  stop_sel_t        sel;

  // Configuration write port
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_cnt_q <= STOP_COUNT_RST;
      stops_q    <= STOPS_RST;
      tab_w_q    <= TAB_WIDTH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_i.index) inside
        CFG_STOP_COUNT: stop_cnt_q <= cfg_i.data[SC_W-1:0];
        [CFG_STOP_0:CFG_STOP_5]: begin
          stops_q[STOP_IDX_W'(cfg_i.index - CFG_STOP_0)] <= cfg_i.data[CNT_W-1:0];
        end
        CFG_TAB_WIDTH: tab_w_q <= cfg_i.data[TW_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (tab_w_q == '0) ? TW_W'(1) : tab_w_q;

  // Next stop lookup and remainder unit
  btc_stop_pick u_stop_pick (
    .stops_i      (stops_q),
    .stop_count_i (stop_cnt_q),
    .width_i      (w_eff),
    .col_i        (col_q),
    .phase_vld_i  (phase_vld_q),
    .phase_i      (phase_q),
    .sel_o        (sel)
  );

  btc_rem_unit u_rem_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // One column step: saturate at the limit, keep the grid phase in step
  assign col_inc   = (col_q == CNT_MAX) ? col_q : col_q + CNT_ONE;
  assign phase_inc = (col_q == CNT_MAX) ? phase_q :
                     ((phase_q + TW_W'(1) == w_eff) ? '0 : phase_q + TW_W'(1));
  assign gap       = sel.stop - col_q;
  assign take_tab  = (sel.stop > col_q) && (pend_q >= gap);

  // Sequencer
  always_comb begin
    state_d          = state_q;
    col_d            = col_q;
    pend_d           = pend_q;
    phase_d          = phase_q;
    phase_vld_d      = phase_vld_q;
    tabs_d           = tabs_q;
    spc_d            = spc_q;
    load_out         = 1'b0;
    rem_req.start    = 1'b0;
    rem_req.dividend = col_q - CNT_ONE;
    rem_req.divisor  = w_eff;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.end_of_stream || (in_i.in_byte != CH_BLANK)) begin
            tabs_d  = '0;
            spc_d   = '0;
            state_d = S_STEP;
          end else if (pend_q != CNT_MAX) begin
            pend_d = pend_q + CNT_ONE;
          end
        end
      end
      S_STEP: begin
        if (eos_q) begin
          // Flush the run as spaces and start a fresh line
          spc_d       = pend_q;
          pend_d      = '0;
          col_d       = CNT_ONE;
          phase_d     = '0;
          phase_vld_d = 1'b1;
          state_d     = S_EMIT;
        end else if (((pend_q != '0) || (byte_q == CH_TAB)) && sel.need_phase) begin
          // Column phase unknown: find (col - 1) mod w first
          rem_req.start = 1'b1;
          state_d       = S_MOD;
        end else if (pend_q != '0) begin
          if (take_tab) begin
            tabs_d      = tabs_q + CNT_ONE;
            pend_d      = pend_q - gap;
            col_d       = sel.stop;
            phase_d     = '0;
            phase_vld_d = !(sel.hit || sel.dflt_clamped);
          end else begin
            spc_d   = spc_q + CNT_ONE;
            pend_d  = pend_q - CNT_ONE;
            col_d   = col_inc;
            phase_d = phase_inc;
          end
        end else begin
          // Run flushed: advance the column over the byte itself
          case (byte_q)
            CH_NEWLINE: begin
              col_d       = CNT_ONE;
              phase_d     = '0;
              phase_vld_d = 1'b1;
            end
            CH_TAB: begin
              col_d       = sel.stop;
              phase_d     = '0;
              phase_vld_d = !(sel.hit || sel.dflt_clamped);
            end
            default: begin
              col_d   = col_inc;
              phase_d = phase_inc;
            end
          endcase
          state_d = S_EMIT;
        end
      end
      S_MOD: begin
        if (rem_rsp.done) begin
          phase_d     = rem_rsp.rem;
          phase_vld_d = 1'b1;
          state_d     = S_STEP;
        end
      end
      S_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A new tab width makes the cached phase stale
    if (cfg_wr && (cfg_i.index == CFG_TAB_WIDTH)) begin
      phase_vld_d = 1'b0;
    end
  end

  assign out_vld_d = load_out ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= CNT_ONE;
      pend_q      <= '0;
      phase_q     <= '0;
      phase_vld_q <= 1'b1;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      pend_q      <= pend_d;
      phase_q     <= phase_d;
      phase_vld_q <= phase_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tabs_q <= tabs_d;
    spc_q  <= spc_d;
    if (in_acc) begin
      byte_q <= in_i.in_byte;
      eos_q  <= in_i.end_of_stream;
    end
    if (load_out) begin
      out_tab_q  <= tabs_q;
      out_spc_q  <= spc_q;
      out_byte_q <= eos_q ? '0 : byte_q;
      out_bv_q   <= !eos_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.tab_count   = out_tab_q;
  assign out_o.space_count = out_spc_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.byte_valid  = out_bv_q;

  // Checks
  a_run_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (pend_q == '0))
    else $error("blank run not fully flushed before the result");

  a_col_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q != '0)
    else $error("column reached zero");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_vld_q |-> (phase_q < w_eff))
    else $error("cached column phase out of range for the tab width");

  a_rem_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_rsp.busy |-> (state_q == S_MOD))
    else $error("remainder unit running outside its wait state");

endmodule

// ===== rtl/core/btc_rem_unit.sv =====
// btc_rem_unit: bit-serial restoring remainder, one dividend bit per cycle.
// Depends on btc_pkg for widths and the request/response structs.

module btc_rem_unit import btc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_req_t req_i,
  output rem_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [BIT_IDX_W-1:0] cnt_q;
  logic [CNT_W-1:0]     sh_q;
  logic [TW_W-1:0]      rem_q;
  logic [TW_W-1:0]      div_q;
  logic [TW_W:0]        partial;
  logic [TW_W-1:0]      rem_nx;

  // Shift in the next dividend bit and subtract the divisor when it fits
  always_comb begin
    partial = {rem_q, sh_q[CNT_W-1]};
    if (partial >= {1'b0, div_q}) begin
      rem_nx = TW_W'(partial - {1'b0, div_q});
    end else begin
      rem_nx = partial[TW_W-1:0];
    end
  end

  // Control: run for one pass over the dividend, pulse done at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= BIT_IDX_W'(CNT_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - BIT_IDX_W'(1);
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      sh_q  <= {sh_q[CNT_W-2:0], 1'b0};
      rem_q <= rem_nx;
    end
  end

  assign rsp_o = '{busy: busy_q, done: done_q, rem: rem_q};

endmodule

// ===== rtl/core/btc_stop_pick.sv =====
// btc_stop_pick: finds the next tab stop above the column, explicit list first,
// then the default grid from the cached column phase. Depends on btc_pkg.

module btc_stop_pick import btc_pkg::*; (
  input  stops_t           stops_i,
  input  logic [SC_W-1:0]  stop_count_i,
  input  logic [TW_W-1:0]  width_i,
  input  logic [CNT_W-1:0] col_i,
  input  logic             phase_vld_i,
  input  logic [TW_W-1:0]  phase_i,
  output stop_sel_t        sel_o
);

  logic [SC_W-1:0]  n_used;
  logic             hit;
  logic [CNT_W-1:0] hit_stop;
  logic [CNT_W:0]   dflt;
  logic             clamped;
  logic             col_zero;

  // Limit the list to the stops the design carries
  assign n_used = (stop_count_i > SC_W'(NUM_STOPS)) ? SC_W'(NUM_STOPS) : stop_count_i;

  // Pick the first listed stop above the column; scan high to low so the lowest index wins
  always_comb begin
    hit      = 1'b0;
    hit_stop = '0;
    for (int i = REG_STOPS - 1; i >= 0; i--) begin
      if ((SC_W'(i) < n_used) && (stops_i[i] > col_i)) begin
        hit      = 1'b1;
        hit_stop = stops_i[i];
      end
    end
  end

  // Default stop: col + w - ((col - 1) mod w), held at the count limit
  assign dflt     = {1'b0, col_i} + CNT_W1'(width_i) - CNT_W1'(phase_i);
  assign clamped  = dflt > {1'b0, CNT_MAX};
  assign col_zero = (col_i == '0);

  always_comb begin
    sel_o.hit          = hit;
    sel_o.need_phase   = !hit && !col_zero && !phase_vld_i;
    sel_o.dflt_clamped = !hit && !col_zero && clamped;
    if (hit) begin
      sel_o.stop = hit_stop;
    end else if (col_zero) begin
      sel_o.stop = CNT_ONE;
    end else if (clamped) begin
      sel_o.stop = CNT_MAX;
    end else begin
      sel_o.stop = dflt[CNT_W-1:0];
    end
  end

endmodule
